FILE: rtl/xfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xfd_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR1     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR2     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_EN    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_LIMIT = 8'd3;

    localparam logic [31:0] TIMEOUT_LIMIT_RST = 32'd100;

    typedef enum logic [2:0] {
        PH_HDR1  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_CMD   = 3'd2,
        PH_LENH  = 3'd3,
        PH_LENL  = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_now;
    } t_in;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic        frame_good;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        logic        timed_out;
    } t_out;

    typedef struct packed {
        logic [7:0]  header_first_byte;
        logic [7:0]  header_second_byte;
        logic        timeout_enable;
        logic [31:0] timeout_limit;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/xfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module xfd_parser
    import xfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire t_in  i_beat,
    input  wire t_cfg i_cfg,
    output t_out      o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_start, n_start;

    logic [31:0] elapsed;
    logic        timeout;
    t_phase      cur_phase;
    logic [15:0] cnt_inc;
    logic [15:0] len_full;

    assign elapsed  = i_beat.time_now - r_start;
    assign timeout  = i_cfg.timeout_enable && (r_phase != PH_HDR1)
                      && (elapsed > i_cfg.timeout_limit);
    assign cur_phase = timeout ? PH_HDR1 : r_phase;
    assign cnt_inc  = r_cnt + 16'd1;
    assign len_full = {r_len[15:8], i_beat.rx_byte};

    // next state
    always_comb begin
        n_phase = cur_phase;
        case (cur_phase)
            PH_HDR1: begin
                if (i_beat.rx_byte == i_cfg.header_first_byte) n_phase = PH_HDR2;
            end
            PH_HDR2: begin
                n_phase = (i_beat.rx_byte == i_cfg.header_second_byte) ? PH_CMD : PH_HDR1;
            end
            PH_CMD:  n_phase = PH_LENH;
            PH_LENH: n_phase = PH_LENL;
            PH_LENL: n_phase = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
            PH_DATA: begin
                if (cnt_inc == r_len) n_phase = PH_CHECK;
            end
            PH_CHECK: n_phase = PH_HDR1;
            default:  n_phase = PH_HDR1;
        endcase
    end

    // result and datapath
    always_comb begin
        o_res           = '0;
        o_res.timed_out = timeout;
        n_xor   = r_xor;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_start = r_start;
        case (cur_phase)
            PH_HDR1: begin
                if (i_beat.rx_byte == i_cfg.header_first_byte) begin
                    n_xor   = i_beat.rx_byte;
                    n_cnt   = 16'd0;
                    n_start = i_beat.time_now;
                end
            end
            PH_HDR2: begin
                if (i_beat.rx_byte == i_cfg.header_second_byte)
                    n_xor = r_xor ^ i_beat.rx_byte;
            end
            PH_CMD: begin
                n_cmd = i_beat.rx_byte;
                n_xor = r_xor ^ i_beat.rx_byte;
            end
            PH_LENH: begin
                n_len = {i_beat.rx_byte, 8'd0};
                n_xor = r_xor ^ i_beat.rx_byte;
            end
            PH_LENL: begin
                n_len = len_full;
                n_xor = r_xor ^ i_beat.rx_byte;
            end
            PH_DATA: begin
                o_res.payload_valid = 1'b1;
                o_res.payload_byte  = i_beat.rx_byte;
                o_res.payload_index = r_cnt;
                n_xor = r_xor ^ i_beat.rx_byte;
                n_cnt = cnt_inc;
            end
            PH_CHECK: begin
                o_res.frame_done    = 1'b1;
                o_res.frame_good    = (i_beat.rx_byte == r_xor);
                o_res.frame_command = r_cmd;
                o_res.frame_length  = r_len;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor   <= 8'd0;
            r_cmd   <= 8'd0;
            r_len   <= 16'd0;
            r_cnt   <= 16'd0;
            r_start <= 32'd0;
        end else if (i_step) begin
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_start <= n_start;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xor8_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted input beat reaches its result beat through the input register, then the result register
// throughput: one byte per cycle while the result side does not stall, with the parser state
// updated between the input register and the result register
// reset: synchronous, active low; clears both valid flags and the parse phase,
// and returns the configuration registers to their reset values

module xor8_frame_deframer
    import xfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire t_in                  i_in,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output t_out                      o_out,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_cfg_ready
);

    t_cfg r_cfg;
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    t_out res;
    logic adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first_byte  <= 8'd0;
            r_cfg.header_second_byte <= 8'd0;
            r_cfg.timeout_enable     <= 1'b0;
            r_cfg.timeout_limit      <= TIMEOUT_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HDR1:     r_cfg.header_first_byte  <= i_cfg_data[7:0];
                CFG_HDR2:     r_cfg.header_second_byte <= i_cfg_data[7:0];
                CFG_TO_EN:    r_cfg.timeout_enable     <= i_cfg_data[0];
                CFG_TO_LIMIT: r_cfg.timeout_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a held beat moves on when the result register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    xfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_beat  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_done_not_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.payload_valid && o_out.frame_done))
        else $error("payload and frame end in one result beat");

    a_good_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.frame_good) |-> o_out.frame_done)
        else $error("frame_good without frame_done");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input beat lost or changed");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advanced beat did not reach result register");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import xfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd4;

    // predicts one result per received byte and checks what the parser emits
    class frame_scoreboard;
        t_cfg        regs;
        t_phase      parse_at;
        logic [7:0]  running_check;
        logic [7:0]  command_seen;
        logic [15:0] length_seen;
        logic [15:0] payload_count;
        logic [31:0] frame_start;
        t_out        expected_results[$];
        int unsigned errors;

        function new();
            regs = '{header_first_byte: 8'h00, header_second_byte: 8'h00,
                     timeout_enable: 1'b0, timeout_limit: TIMEOUT_LIMIT_RST};
            parse_at = PH_HDR1;
            running_check = '0;
            command_seen = '0;
            length_seen = '0;
            payload_count = '0;
            frame_start = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_HDR1:     regs.header_first_byte = data[7:0];
                CFG_HDR2:     regs.header_second_byte = data[7:0];
                CFG_TO_EN:    regs.timeout_enable = data[0];
                CFG_TO_LIMIT: regs.timeout_limit = data;
                default: ;
            endcase
        endfunction

        function t_out parse_byte(t_in d);
            t_out        r;
            logic [31:0] elapsed;
            r = '0;
            if (regs.timeout_enable && parse_at != PH_HDR1) begin
                elapsed = d.time_now - frame_start;
                if (elapsed > regs.timeout_limit) begin
                    parse_at = PH_HDR1;
                    r.timed_out = 1'b1;
                end
            end
            case (parse_at)
                PH_HDR1: begin
                    if (d.rx_byte == regs.header_first_byte) begin
                        parse_at = PH_HDR2;
                        running_check = d.rx_byte;
                        payload_count = '0;
                        frame_start = d.time_now;
                    end
                end
                PH_HDR2: begin
                    if (d.rx_byte == regs.header_second_byte) begin
                        parse_at = PH_CMD;
                        running_check ^= d.rx_byte;
                    end else begin
                        parse_at = PH_HDR1;
                    end
                end
                PH_CMD: begin
                    command_seen = d.rx_byte;
                    running_check ^= d.rx_byte;
                    parse_at = PH_LENH;
                end
                PH_LENH: begin
                    length_seen = {d.rx_byte, 8'h00};
                    running_check ^= d.rx_byte;
                    parse_at = PH_LENL;
                end
                PH_LENL: begin
                    length_seen[7:0] = d.rx_byte;
                    running_check ^= d.rx_byte;
                    parse_at = (length_seen == 16'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = d.rx_byte;
                    r.payload_index = payload_count;
                    running_check ^= d.rx_byte;
                    payload_count = payload_count + 16'd1;
                    if (payload_count == length_seen) parse_at = PH_CHECK;
                end
                default: begin
                    r.frame_done = 1'b1;
                    r.frame_good = (d.rx_byte == running_check);
                    r.frame_command = command_seen;
                    r.frame_length = length_seen;
                    parse_at = PH_HDR1;
                end
            endcase
            return r;
        endfunction

        function void note_rx_byte(t_in d);
            expected_results.push_back(parse_byte(d));
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        task report(string what, logic [63:0] got_v, logic [63:0] want_v);
            if (errors < 40) $display("mismatch %s: got %0h expected %0h", what, got_v, want_v);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                report("beat with nothing expected", got, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.payload_valid !== want.payload_valid)
                report("payload_valid", got.payload_valid, want.payload_valid);
            if (got.payload_byte !== want.payload_byte)
                report("payload_byte", got.payload_byte, want.payload_byte);
            if (got.payload_index !== want.payload_index)
                report("payload_index", got.payload_index, want.payload_index);
            if (got.frame_done !== want.frame_done)
                report("frame_done", got.frame_done, want.frame_done);
            if (got.frame_good !== want.frame_good)
                report("frame_good", got.frame_good, want.frame_good);
            if (got.frame_command !== want.frame_command)
                report("frame_command", got.frame_command, want.frame_command);
            if (got.frame_length !== want.frame_length)
                report("frame_length", got.frame_length, want.frame_length);
            if (got.timed_out !== want.timed_out)
                report("timed_out", got.timed_out, want.timed_out);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    t_in                  i_in;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out;
    logic                 i_out_stall;
    logic                 i_cfg_valid;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 o_cfg_ready;

    frame_scoreboard sb;
    logic [31:0]     stamp;
    int unsigned     bytes_sent;
    int unsigned     idle_pct;
    int unsigned     stall_pct;

    xor8_frame_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted beats, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_byte(logic [7:0] b);
        t_in d;
        d.rx_byte = b;
        d.time_now = stamp;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= d;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_rx_byte(d);
        bytes_sent++;
    endtask

    task automatic send_at(logic [7:0] b, logic [31:0] t);
        stamp = t;
        send_byte(b);
    endtask

    task automatic write_reg_beat(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // upper data bits are random, the registers must only keep their own width
    task automatic set_config(logic [7:0] h1, logic [7:0] h2, logic en, logic [31:0] lim);
        logic [31:0] data;
        data = $urandom;
        data[7:0] = h1;
        write_reg_beat(CFG_HDR1, data);
        data = $urandom;
        data[7:0] = h2;
        write_reg_beat(CFG_HDR2, data);
        data = $urandom;
        data[0] = en;
        write_reg_beat(CFG_TO_EN, data);
        write_reg_beat(CFG_TO_LIMIT, lim);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle_outputs();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic bit can_expire();
        return sb.regs.timeout_enable && sb.regs.timeout_limit <= 32'hFFFF_FF00;
    endfunction

    task automatic send_frame(logic [7:0] cmd, logic [15:0] len, bit corrupt);
        logic [7:0]  frame_q[$];
        logic [7:0]  sum;
        int unsigned step;
        int unsigned pick;
        // keep the whole frame inside the time limit when it is tight
        step = (sb.regs.timeout_enable && sb.regs.timeout_limit < 32'(len) * 3 + 18) ? 0 : 3;
        frame_q = {sb.regs.header_first_byte, sb.regs.header_second_byte, cmd,
                   len[15:8], len[7:0]};
        repeat (len) frame_q.push_back(8'($urandom));
        sum = '0;
        foreach (frame_q[i]) sum ^= frame_q[i];
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
        pick = $urandom_range(0, 19);
        if (pick < 6) stamp = $urandom;
        else if (pick == 6) stamp = 32'hFFFF_FFFF - $urandom_range(0, 8);
        foreach (frame_q[i]) begin
            if (i != 0) stamp += $urandom_range(0, step);
            send_byte(frame_q[i]);
        end
    endtask

    task automatic send_broken();
        logic [31:0] start;
        logic [7:0]  b;
        logic [15:0] len;
        start = stamp;
        send_byte(sb.regs.header_first_byte);
        if ($urandom_range(0, 2) == 0) begin
            b = 8'($urandom);
            if (b == sb.regs.header_second_byte) b = ~b;
            send_byte(b);
            return;
        end
        send_byte(sb.regs.header_second_byte);
        send_byte(8'($urandom));
        len = can_expire() ? 16'($urandom) : 16'($urandom_range(0, 15));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
        // the next byte lands past the limit and abandons the frame
        if (can_expire()) stamp = start + sb.regs.timeout_limit + 1 + $urandom_range(0, 50);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 9) == 0) stamp = $urandom;
            else stamp += $urandom_range(0, 3);
            send_byte(($urandom_range(0, 9) == 0) ? sb.regs.header_first_byte : 8'($urandom));
        end
    endtask

    initial begin
        int unsigned target;
        int unsigned pick;
        logic [15:0] len;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        idle_pct = 0;
        stall_pct = 0;
        stamp = '0;
        bytes_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset headers, zero length frame
        send_at(8'h00, 0);
        send_at(8'h00, 1);
        send_at(8'hFF, 2);
        send_at(8'h00, 3);
        send_at(8'h00, 4);
        send_at(8'hFF, 5);
        settle_outputs();
        write_reg_beat(CFG_UNUSED, $urandom);
        set_config(8'hA5, 8'h5A, 1'b1, TIMEOUT_LIMIT_RST);
        // wrong second header byte
        send_at(8'hA5, 10);
        send_at(8'h00, 11);
        // one byte payload with a bad check byte
        send_at(8'hA5, 20);
        send_at(8'h5A, 21);
        send_at(8'h00, 22);
        send_at(8'h00, 23);
        send_at(8'h01, 24);
        send_at(8'hFF, 25);
        send_at(8'h81, 26);
        // abandoned by timeout on a non-header byte
        send_at(8'hA5, 1000);
        send_at(8'h5A, 1001);
        send_at(8'h12, 1101);
        // exactly at the limit still runs, one past restarts on a header byte
        send_at(8'hA5, 2000);
        send_at(8'h5A, 2001);
        send_at(8'h7E, 2100);
        send_at(8'hA5, 2101);
        send_at(8'h5A, 2102);
        send_at(8'h3C, 2103);
        send_at(8'h00, 2104);
        send_at(8'h00, 2105);
        send_at(8'hC3, 2106);

        for (int phase_no = 0; phase_no < 8; phase_no++) begin
            settle_outputs();
            case (phase_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            case (phase_no % 6)
                0: set_config(8'($urandom), 8'($urandom), 1'b1, TIMEOUT_LIMIT_RST);
                1: set_config(8'hFF, 8'hFF, 1'b1, 32'd0);
                2: set_config(8'h00, 8'h00, 1'b0, 32'hFFFF_FFFF);
                3: set_config(8'($urandom), 8'($urandom), 1'b1, 32'hFFFF_FFFF);
                4: set_config(8'($urandom), 8'($urandom), 1'b1, $urandom_range(8, 40));
                default: set_config(8'($urandom), 8'($urandom), 1'b0, $urandom);
            endcase
            target = bytes_sent + 90;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                                      : 16'($urandom_range(0, 6));
                    send_frame(8'($urandom), len, $urandom_range(0, 9) == 0);
                end else if (pick < 80) begin
                    send_broken();
                end else begin
                    send_noise();
                end
            end
        end

        settle_outputs();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/xfd_pkg.sv
rtl/xfd_parser.sv
rtl/xor8_frame_deframer.sv
tb/tb.sv
